// ----- rtl/hrlp_pkg.sv -----
// Package with the shared types and constants of the hex request line parser.
`timescale 1ns / 1ps

package hrlp_pkg;

  localparam int COUNT_W = 13;

  localparam logic [COUNT_W-1:0] LONG_LIMIT  = 13'd4095;
  localparam logic [COUNT_W-1:0] SHORT_LIMIT = 13'd8;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;
  localparam logic [7:0] CHAR_LO_Z  = 8'h7a;
  localparam logic [7:0] CASE_FOLD  = 8'd32;
  localparam logic [7:0] HEX_TEN    = 8'd10;

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_CHAR   = 2'd1,
    STATUS_BAD_NIBBLE = 2'd2,
    STATUS_OVERSIZED  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_BYTE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_t;

  typedef struct packed {
    logic       is_space;
    logic       is_hex;
    logic [3:0] value;
  } char_class_t;

endpackage

// ----- rtl/hrlp_stream_if.sv -----
// Valid/ready channel interfaces for the character input and the result output.
`timescale 1ns / 1ps

interface hrlp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       line_end;

  modport source (output valid, output ch, output line_end, input ready);
  modport sink (input valid, input ch, input line_end, output ready);
endinterface

interface hrlp_result_if;
  import hrlp_pkg::*;

  logic               valid;
  logic               ready;
  logic               kind;
  logic [7:0]         data_byte;
  logic [1:0]         status;
  logic               has_response_count;
  logic [3:0]         response_count;
  logic [COUNT_W-1:0] byte_count;

  modport source (output valid, output kind, output data_byte, output status,
                  output has_response_count, output response_count,
                  output byte_count, input ready);
  modport sink (input valid, input kind, input data_byte, input status,
                input has_response_count, input response_count,
                input byte_count, output ready);
endinterface

// ----- rtl/hrlp_char_class.sv -----
// Character classifier: space detect, case fold and hex digit decode.
`timescale 1ns / 1ps

module hrlp_char_class (
  input  logic [7:0]           ch,
  output hrlp_pkg::char_class_t cls
);
  import hrlp_pkg::*;

  logic [7:0] folded;

  always_comb begin
    if (ch >= CHAR_LO_A && ch <= CHAR_LO_Z) begin
      folded = ch - CASE_FOLD;
    end else begin
      folded = ch;
    end

    cls.is_space = (ch == CHAR_SPACE);
    cls.is_hex   = 1'b0;
    cls.value    = 4'd0;
    if (folded >= CHAR_ZERO && folded <= CHAR_NINE) begin
      cls.is_hex = 1'b1;
      cls.value  = 4'(folded - CHAR_ZERO);
    end else if (folded >= CHAR_UP_A && folded <= CHAR_UP_F) begin
      cls.is_hex = 1'b1;
      cls.value  = 4'(folded - CHAR_UP_A + HEX_TEN);
    end
  end

endmodule

// ----- rtl/hex_request_line_parser.sv -----
// Top level of the hex request line parser.
`timescale 1ns / 1ps

// Takes one character request per cycle when the output is not stalled and
// gives at most one result per character: a payload byte for every second
// digit, and one status result for each end-of-line request. An accepted
// request first sits in the input register, where the line state is
// updated, and its result then waits in the output register; with the
// output taken every cycle the block sustains one request per clock.
// Payload bytes already delivered must be dropped downstream when the line
// status is not ok; after a bad character or past the byte limit no
// further bytes are delivered. cfg_we/cfg_wdata write auto_format_on
// (reset 1: limit 4095 bytes; 0: limit 8 bytes); the user must see that they
// are only written while the block is idle, the block itself does not enforce this.
module hex_request_line_parser (
  input  logic      clk,
  input  logic      rst,
  hrlp_char_if.sink   chars,
  hrlp_result_if.source results,
  input  logic      cfg_we,
  input  logic      cfg_wdata
);
  import hrlp_pkg::*;

  // Configuration.
  logic auto_format_on;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_ch;
  logic       s1_line_end;

  // Line state.
  logic [3:0]         held_nibble;
  logic               nibble_pending;
  logic [COUNT_W-1:0] payload_count;
  logic               bad_char_seen;

  logic [3:0]         held_nibble_next;
  logic               nibble_pending_next;
  logic [COUNT_W-1:0] payload_count_next;
  logic               bad_char_seen_next;

  // Output register.
  logic               o_valid;
  kind_t              o_kind;
  logic [7:0]         o_data_byte;
  status_t            o_status;
  logic               o_has_rc;
  logic [3:0]         o_rc;
  logic [COUNT_W-1:0] o_byte_count;

  logic               emit;
  kind_t              r_kind;
  logic [7:0]         r_data_byte;
  status_t            r_status;
  logic               r_has_rc;
  logic [3:0]         r_rc;
  logic [COUNT_W-1:0] r_byte_count;

  logic               s1_advance;
  logic [COUNT_W-1:0] limit;
  logic [COUNT_W-1:0] cap;
  logic               bad_now;
  char_class_t        cls;

  hrlp_char_class u_class (
    .ch  (s1_ch),
    .cls (cls)
  );

  assign s1_advance   = s1_valid && (!o_valid || results.ready);
  assign chars.ready  = !s1_valid || s1_advance;

  assign limit = auto_format_on ? LONG_LIMIT : SHORT_LIMIT;
  assign cap   = limit + COUNT_W'(1);

  always_comb begin
    held_nibble_next    = held_nibble;
    nibble_pending_next = nibble_pending;
    payload_count_next  = payload_count;
    bad_char_seen_next  = bad_char_seen;
    bad_now             = bad_char_seen || !cls.is_hex;

    emit         = 1'b0;
    r_kind       = KIND_BYTE;
    r_data_byte  = 8'd0;
    r_status     = STATUS_OK;
    r_has_rc     = 1'b0;
    r_rc         = 4'd0;
    r_byte_count = payload_count;

    if (s1_line_end) begin
      emit   = 1'b1;
      r_kind = KIND_STATUS;
      if (bad_char_seen) begin
        r_status = STATUS_BAD_CHAR;
      end else if (nibble_pending &&
                   (held_nibble == 4'd0 || payload_count == '0)) begin
        r_status = STATUS_BAD_NIBBLE;
      end else if (payload_count > limit) begin
        r_status = STATUS_OVERSIZED;
      end
      if (r_status == STATUS_OK && nibble_pending) begin
        r_has_rc = 1'b1;
        r_rc     = held_nibble;
      end
      held_nibble_next    = 4'd0;
      nibble_pending_next = 1'b0;
      payload_count_next  = '0;
      bad_char_seen_next  = 1'b0;
    end else if (!cls.is_space) begin
      bad_char_seen_next = bad_now;
      if (!nibble_pending) begin
        held_nibble_next    = cls.value;
        nibble_pending_next = 1'b1;
      end else begin
        nibble_pending_next = 1'b0;
        if (payload_count < cap) begin
          payload_count_next = payload_count + COUNT_W'(1);
        end
        // Bytes stop for the rest of the line after a bad character or past the byte limit.
        emit         = !bad_now && (payload_count_next <= limit);
        r_data_byte  = {held_nibble, cls.value};
        r_byte_count = payload_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      auto_format_on <= 1'b1;
    end else if (cfg_we) begin
      auto_format_on <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_ch       <= chars.ch;
      s1_line_end <= chars.line_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_nibble    <= 4'd0;
      nibble_pending <= 1'b0;
      payload_count  <= '0;
      bad_char_seen  <= 1'b0;
    end else if (s1_advance) begin
      held_nibble    <= held_nibble_next;
      nibble_pending <= nibble_pending_next;
      payload_count  <= payload_count_next;
      bad_char_seen  <= bad_char_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_advance && emit) begin
      o_valid <= 1'b1;
    end else if (results.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && emit) begin
      o_kind       <= r_kind;
      o_data_byte  <= r_data_byte;
      o_status     <= r_status;
      o_has_rc     <= r_has_rc;
      o_rc         <= r_rc;
      o_byte_count <= r_byte_count;
    end
  end

  assign results.valid              = o_valid;
  assign results.kind               = o_kind;
  assign results.data_byte          = o_data_byte;
  assign results.status             = o_status;
  assign results.has_response_count = o_has_rc;
  assign results.response_count     = o_rc;
  assign results.byte_count         = o_byte_count;

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the hex request line parser.
`timescale 1ns / 1ps

module tb_top;
  import hrlp_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    logic [7:0] ch;
    logic       line_end;
  } char_req_t;

  typedef struct {
    kind_t              kind;
    logic [7:0]         data_byte;
    status_t            status;
    logic               has_rc;
    logic [3:0]         rc;
    logic [COUNT_W-1:0] byte_count;
  } line_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;

  hrlp_char_if   chars_if ();
  hrlp_result_if res_if ();

  hex_request_line_parser DUT (
    .clk       (clk),
    .rst       (rst),
    .chars     (chars_if),
    .results   (res_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  char_req_t    pending_chars[$];
  line_result_t awaited_results[$];
  int unsigned  chars_queued;
  int unsigned  mismatches;
  int unsigned  idle_cycles;
  int unsigned  send_wait;
  int unsigned  recv_wait;
  logic         char_taken;
  bit           steady;

  // Predictor copy of the line state and the configuration.
  logic               fmt_long;
  logic [3:0]         first_digit;
  logic               digit_pending;
  logic [COUNT_W-1:0] pair_count;
  logic               saw_bad_char;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and now and then a stretch with none.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if ($urandom_range(0, 199) == 0) steady = !steady;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bit 4 is set for a character that is not a hex digit.
  function automatic logic [4:0] classify_digit(logic [7:0] c);
    if (c >= CHAR_LO_A && c <= CHAR_LO_Z) c = c - CASE_FOLD;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return {1'b0, 4'(c - CHAR_ZERO)};
    if (c >= CHAR_UP_A && c <= CHAR_UP_F) return {1'b0, 4'(c - CHAR_UP_A + HEX_TEN)};
    return 5'b10000;
  endfunction

  task automatic decode_char(logic [7:0] c, logic line_end);
    logic [COUNT_W-1:0] limit;
    logic [4:0]         digit;
    line_result_t       res;
    limit = fmt_long ? LONG_LIMIT : SHORT_LIMIT;
    res = '{KIND_BYTE, 8'h00, STATUS_OK, 1'b0, 4'h0, '0};
    if (line_end) begin
      res.kind = KIND_STATUS;
      if (saw_bad_char) res.status = STATUS_BAD_CHAR;
      else if (digit_pending && (first_digit == 4'h0 || pair_count == 0))
        res.status = STATUS_BAD_NIBBLE;
      else if (pair_count > limit) res.status = STATUS_OVERSIZED;
      if (res.status == STATUS_OK && digit_pending) begin
        res.has_rc = 1'b1;
        res.rc = first_digit;
      end
      res.byte_count = pair_count;
      awaited_results.push_back(res);
      first_digit = 4'h0;
      digit_pending = 1'b0;
      pair_count = '0;
      saw_bad_char = 1'b0;
    end else if (c != CHAR_SPACE) begin
      digit = classify_digit(c);
      if (digit[4]) begin
        saw_bad_char = 1'b1;
        digit = 5'b0;
      end
      if (!digit_pending) begin
        first_digit = digit[3:0];
        digit_pending = 1'b1;
      end else begin
        digit_pending = 1'b0;
        // The count saturates one above the limit.
        if (pair_count <= limit) pair_count = pair_count + 1'b1;
        if (!saw_bad_char && pair_count <= limit) begin
          res.data_byte = {first_digit, digit[3:0]};
          res.byte_count = pair_count;
          awaited_results.push_back(res);
        end
      end
    end
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Request driver.
  always @(negedge clk) begin : char_driver
    char_req_t next_req;
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else if (!(chars_if.valid && !char_taken)) begin
      if (send_wait > 0) begin
        send_wait--;
        chars_if.valid <= 1'b0;
      end else if (pending_chars.size() > 0) begin
        next_req = pending_chars.pop_front();
        chars_if.ch <= next_req.ch;
        chars_if.line_end <= next_req.line_end;
        chars_if.valid <= 1'b1;
        send_wait = pick_gap();
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
  end

  // Result sink with random stalls.
  always @(negedge clk) begin
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (recv_wait > 0) begin
      recv_wait--;
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= 1'b1;
      recv_wait = pick_gap();
    end
  end

  // Monitor: predicts on accepted requests, checks delivered results.
  always @(posedge clk) begin : monitor
    line_result_t want;
    char_taken <= chars_if.valid && chars_if.ready;
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual kind %0d byte %0h",
                   $time, res_if.kind, res_if.data_byte);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("kind", want.kind, res_if.kind);
          check_field("data_byte", want.data_byte, res_if.data_byte);
          check_field("status", want.status, res_if.status);
          check_field("has_response_count", want.has_rc, res_if.has_response_count);
          check_field("response_count", want.rc, res_if.response_count);
          check_field("byte_count", want.byte_count, res_if.byte_count);
        end
      end
      if (chars_if.valid && chars_if.ready)
        decode_char(chars_if.ch, chars_if.line_end);
      if ((chars_if.valid && chars_if.ready) || (res_if.valid && res_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return CHAR_ZERO + v;
    return ($urandom_range(0, 1) ? CHAR_LO_A : CHAR_UP_A) + v - HEX_TEN;
  endfunction

  task automatic push_char(logic [7:0] c);
    pending_chars.push_back('{ch: c, line_end: 1'b0});
    chars_queued++;
  endtask

  // The character under an end-of-line request is don't-care, so it is random.
  task automatic push_end();
    pending_chars.push_back('{ch: 8'($urandom_range(0, 255)), line_end: 1'b1});
    chars_queued++;
  endtask

  // A line of nbytes digit pairs, an optional trailing digit, stray spaces, and
  // when garbled one random character at a random spot.
  task automatic push_line(int unsigned nbytes, bit odd_digit, bit garbled);
    int unsigned ndig;
    int unsigned bad_pos;
    ndig = 2 * nbytes + odd_digit;
    bad_pos = garbled ? $urandom_range(0, ndig) : ndig + 1;
    for (int unsigned i = 0; i <= ndig; i++) begin
      if (i == bad_pos) push_char(8'($urandom_range(0, 255)));
      if (i < ndig) begin
        if ($urandom_range(0, 7) == 0) push_char(CHAR_SPACE);
        push_char(hex_char(4'($urandom_range(0, 15))));
      end
    end
    push_end();
  endtask

  task automatic wait_until_idle();
    while (pending_chars.size() != 0 || chars_if.valid || awaited_results.size() != 0)
      @(posedge clk);
    // A trailing space request yields nothing and may still be in flight.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_auto_format(logic v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    fmt_long = v;
  endtask

  task automatic random_lines(int unsigned target);
    int unsigned start;
    int unsigned r;
    int unsigned n;
    start = chars_queued;
    while (chars_queued - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        push_line($urandom_range(0, 12), $urandom_range(0, 9) < 4, r >= 70);
      end else begin
        n = $urandom_range(0, 6);
        repeat (n) push_char($urandom_range(0, 3) == 0 ? CHAR_SPACE
                                                        : 8'($urandom_range(0, 255)));
        push_end();
      end
      // Occasionally hold the sender until every pending result is back.
      if ($urandom_range(0, 24) == 0) wait_until_idle();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    chars_if.valid = 1'b0;
    chars_if.ch = 8'h00;
    chars_if.line_end = 1'b0;
    res_if.ready = 1'b0;
    char_taken = 1'b0;
    send_wait = 0;
    recv_wait = 0;
    steady = 1'b0;
    chars_queued = 0;
    mismatches = 0;
    idle_cycles = 0;
    fmt_long = 1'b1;
    first_digit = 4'h0;
    digit_pending = 1'b0;
    pair_count = '0;
    saw_bad_char = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Empty line and a line of only a space.
    push_end();
    push_char(CHAR_SPACE);
    push_end();
    // Mixed case, the byte extremes and a response count.
    push_char("f");
    push_char("F");
    push_char("0");
    push_char(CHAR_SPACE);
    push_char("0");
    push_char("7");
    push_end();
    // A lone digit with no payload in front of it.
    push_char("5");
    push_end();
    // Trailing zero digit after a byte.
    push_char("A");
    push_char("b");
    push_char("0");
    push_end();
    // NUL, the top character code and a letter past F.
    push_char(8'h00);
    push_char("1");
    push_end();
    push_char("1");
    push_char(8'hff);
    push_char("g");
    push_char("z");
    push_end();
    wait_until_idle();

    write_auto_format(1'b0);
    random_lines(700);
    wait_until_idle();

    write_auto_format(1'b1);
    random_lines(600);
    wait_until_idle();

    write_auto_format(1'b0);
    random_lines(350);
    wait_until_idle();

    write_auto_format(1'b1);
    random_lines(350);
    wait_until_idle();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
